/* design/seven_segment_scan_with_keypad_edit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the seven-segment scan and keypad edit block
// Shared property forms used by the modules that carry assertions.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SCAN_WITH_KEYPAD_EDIT_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_WITH_KEYPAD_EDIT_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define SSKP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sskp: same-cycle check failed");

// consequent holds in the cycle after the antecedent
`define SSKP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sskp: next-cycle check failed");

`endif

/* design/sskp_pkg.sv */
// ----------------------------------------------------------------------------
// sskp_pkg
// Types, codes and constant tables for the display scan and keypad edit block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sskp_pkg;

    localparam int TICK_W     = 16;
    localparam int DIV_W      = 8;
    localparam int SEC_W      = 4;
    localparam int OP_W       = 2;
    localparam int SENSE_W    = 7;
    localparam int BTN_W      = 2;
    localparam int KEY_W      = 4;
    localparam int ROW_W      = 2;
    localparam int DRIVE_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_SCAN   = 2'd1;
    localparam logic [OP_W-1:0] OP_BUTTON = 2'd2;

    localparam logic [BTN_W-1:0] BTN_SCROLL_UP   = 2'd0;
    localparam logic [BTN_W-1:0] BTN_SCROLL_DOWN = 2'd1;
    localparam logic [BTN_W-1:0] BTN_DIV_UP      = 2'd2;
    localparam logic [BTN_W-1:0] BTN_DIV_DOWN    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TICKS = 2'd1;

    localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 16'd976;
    localparam logic [TICK_W-1:0] BLINK_TICKS_RST = 16'd488;

    localparam logic [DIV_W-1:0] DIVISOR_RST = 8'd4;
    localparam logic [DIV_W-1:0] DIVISOR_MIN = 8'd1;
    localparam logic [DIV_W-1:0] DIVISOR_MAX = 8'd255;

    localparam logic [DRIVE_W-1:0] ROW_BASE = 7'h08;

    localparam int NUM_KEYS = 12;
    localparam logic [KEY_W-1:0] KEY_CURSOR_DOWN = 4'd10;
    localparam logic [KEY_W-1:0] KEY_CURSOR_UP   = 4'd11;
    localparam logic [KEY_W-1:0] KEY_NONE        = 4'd15;

    localparam logic [SENSE_W-1:0] KEY_CODES [NUM_KEYS] = '{
        7'd69, 7'd14, 7'd13, 7'd11, 7'd22, 7'd21,
        7'd19, 7'd38, 7'd37, 7'd35, 7'd67, 7'd70
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REM,
        ST_APPLY
    } t_state;

    typedef struct packed {
        logic load;
        logic rem_start;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic in_tick;
        logic rem_idle;
    } t_sts;

    function automatic logic [KEY_W-1:0] key_lookup(input logic [SENSE_W-1:0] sense);
        logic [KEY_W-1:0] k;
        k = KEY_NONE;
        for (int i = NUM_KEYS - 1; i >= 0; i--) begin
            if (sense == KEY_CODES[i]) begin
                k = KEY_W'(i);
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

/* design/sskp_rem.sv */
// ----------------------------------------------------------------------------
// sskp_rem
// Bit-serial restoring remainder of the tick count by the PWM divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "seven_segment_scan_with_keypad_edit_assert.svh"

module sskp_rem (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [sskp_pkg::TICK_W-1:0] i_dividend,
    input  wire logic [sskp_pkg::DIV_W-1:0]  i_divisor,
    output logic                             o_idle,
    output logic                             o_zero
);
    import sskp_pkg::*;

    localparam int CNT_W = $clog2(TICK_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TICK_W - 1);

    logic [TICK_W-1:0] r_quo;
    logic [DIV_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;

    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic              fits;
    logic [DIV_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_quo[TICK_W-1]};
        diff  = trial - {1'b0, i_divisor};
        fits  = (trial >= {1'b0, i_divisor});
        n_rem = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[TICK_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_idle = !r_busy;
    assign o_zero = (r_rem == '0);

    `SSKP_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy && r_rem == '0)
    `SSKP_ASSERT_NEXT(a_last_step, i_clk, i_rst_n, r_busy && r_cnt == CNT_LAST && !i_start, !r_busy && r_cnt == '0)
    `SSKP_ASSERT_SAME(a_idle_count, i_clk, i_rst_n, !r_busy, r_cnt == '0)

endmodule

`default_nettype wire

/* design/sskp_dpath.sv */
// ----------------------------------------------------------------------------
// sskp_dpath
// Item latch, display and keypad state, configuration and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sskp_dpath #(
    parameter int NUM_DIGITS  = 8,
    parameter int SCAN_DIGITS = 4
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire sskp_pkg::t_cmd                   i_cmd,
    output sskp_pkg::t_sts                        o_sts,
    input  wire logic [sskp_pkg::OP_W-1:0]        i_op,
    input  wire logic [sskp_pkg::SENSE_W-1:0]     i_sense,
    input  wire logic [sskp_pkg::BTN_W-1:0]       i_code,
    input  wire logic                             i_cfg_we,
    input  wire logic [sskp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sskp_pkg::TICK_W-1:0]      i_cfg_data,
    output logic [sskp_pkg::OUT_DATA_W-1:0]       o_out_data
);
    import sskp_pkg::*;

    localparam int DW        = (NUM_DIGITS > 2) ? $clog2(NUM_DIGITS) : 1;
    localparam int SW        = (SCAN_DIGITS > 2) ? $clog2(SCAN_DIGITS) : 1;
    localparam int SUMW      = ((DW > SW) ? DW : SW) + 1;
    localparam int MOD_STEPS = (SCAN_DIGITS + NUM_DIGITS - 2) / NUM_DIGITS;
    localparam logic [DW-1:0] DIG_LAST  = DW'(NUM_DIGITS - 1);
    localparam logic [SW-1:0] SCAN_LAST = SW'(SCAN_DIGITS - 1);

    logic [OP_W-1:0]    r_op;
    logic [SENSE_W-1:0] r_sense;
    logic [BTN_W-1:0]   r_code;

    logic [TICK_W-1:0]  r_tick_period;
    logic [TICK_W-1:0]  r_blink_ticks;

    logic [TICK_W-1:0]  r_tick,    n_tick;
    logic [SEC_W-1:0]   r_sec,     n_sec;
    logic [SW-1:0]      r_scan,    n_scan;
    logic [DW-1:0]      r_scroll,  n_scroll;
    logic [DW-1:0]      r_cursor,  n_cursor;
    logic [DIV_W-1:0]   r_divisor, n_divisor;
    logic [ROW_W-1:0]   r_row,     n_row;
    logic [KEY_W-1:0]   r_digits [NUM_DIGITS];
    logic               n_dig_we;

    logic [OUT_DATA_W-1:0] r_out_data;

    logic [TICK_W:0]    tick_inc;
    logic [TICK_W-1:0]  tick_nxt;
    logic               sec_step;
    logic [SW-1:0]      scan_nxt;
    logic [SUMW-1:0]    idx_sum;
    logic [DW-1:0]      idx;
    logic               blank;
    logic [KEY_W-1:0]   key;
    logic               rem_idle;
    logic               rem_zero;
    logic [7:0]         port;
    logic               led;
    logic [DW+2:0]      cursor_ext;
    logic [SW+1:0]      scan_ext;
    logic [DRIVE_W-1:0] row_drive;

    sskp_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.rem_start),
        .i_dividend (r_tick),
        .i_divisor  (r_divisor),
        .o_idle     (rem_idle),
        .o_zero     (rem_zero)
    );

    assign o_sts.in_tick  = (i_op == OP_TICK);
    assign o_sts.rem_idle = rem_idle;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_sense <= i_sense;
            r_code  <= i_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period <= TICK_PERIOD_RST;
            r_blink_ticks <= BLINK_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TICK_PERIOD: r_tick_period <= i_cfg_data;
                CFG_BLINK_TICKS: r_blink_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        tick_inc = {1'b0, r_tick} + (TICK_W + 1)'(1);
        tick_nxt = (tick_inc >= {1'b0, r_tick_period}) ? '0 : tick_inc[TICK_W-1:0];
        sec_step = (tick_nxt == (r_tick_period - TICK_W'(1)));
        scan_nxt = (r_scan == SCAN_LAST) ? '0 : r_scan + SW'(1);
    end

    always_comb begin
        idx_sum = SUMW'(scan_nxt) + SUMW'(r_scroll);
        for (int s = 0; s < MOD_STEPS; s++) begin
            if (idx_sum >= SUMW'(NUM_DIGITS)) begin
                idx_sum = idx_sum - SUMW'(NUM_DIGITS);
            end
        end
    end

    assign idx   = idx_sum[DW-1:0];
    assign blank = (idx == r_cursor) && (tick_nxt < r_blink_ticks);
    assign key   = key_lookup(r_sense);

    always_comb begin
        n_tick    = r_tick;
        n_sec     = r_sec;
        n_scan    = r_scan;
        n_scroll  = r_scroll;
        n_cursor  = r_cursor;
        n_divisor = r_divisor;
        n_row     = r_row;
        n_dig_we  = 1'b0;
        unique case (r_op)
            OP_TICK: begin
                n_tick = tick_nxt;
                n_scan = scan_nxt;
                if (sec_step) begin
                    n_sec = r_sec + SEC_W'(1);
                end
            end
            OP_SCAN: begin
                n_row = r_row + ROW_W'(1);
                if (key == KEY_CURSOR_DOWN) begin
                    n_cursor = (r_cursor == '0) ? DIG_LAST : r_cursor - DW'(1);
                end else if (key == KEY_CURSOR_UP) begin
                    n_cursor = (r_cursor == DIG_LAST) ? '0 : r_cursor + DW'(1);
                end else if (key < KEY_CURSOR_DOWN) begin
                    n_dig_we = 1'b1;
                end
            end
            OP_BUTTON: begin
                unique case (r_code)
                    BTN_SCROLL_UP: begin
                        n_scroll = (r_scroll == DIG_LAST) ? '0 : r_scroll + DW'(1);
                    end
                    BTN_SCROLL_DOWN: begin
                        n_scroll = (r_scroll == '0) ? DIG_LAST : r_scroll - DW'(1);
                    end
                    BTN_DIV_UP: begin
                        if (r_divisor < DIVISOR_MAX) begin
                            n_divisor = r_divisor + DIV_W'(1);
                        end
                    end
                    BTN_DIV_DOWN: begin
                        if (r_divisor > DIVISOR_MIN) begin
                            n_divisor = r_divisor - DIV_W'(1);
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        cursor_ext = {3'b000, n_cursor};
        scan_ext   = {2'b00, scan_nxt};
        row_drive  = ROW_BASE << n_row;
        if (r_op == OP_TICK) begin
            port = {!blank, 1'b0, scan_ext[1:0], r_digits[idx]};
            led  = rem_zero;
        end else begin
            port = '0;
            led  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= '0;
            r_sec     <= '0;
            r_scan    <= '0;
            r_scroll  <= DW'(4 % NUM_DIGITS);
            r_cursor  <= DW'(7 % NUM_DIGITS);
            r_divisor <= DIVISOR_RST;
            r_row     <= '0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_digits[i] <= KEY_W'((NUM_DIGITS - i) & 15);
            end
        end else if (i_cmd.commit) begin
            r_tick    <= n_tick;
            r_sec     <= n_sec;
            r_scan    <= n_scan;
            r_scroll  <= n_scroll;
            r_cursor  <= n_cursor;
            r_divisor <= n_divisor;
            r_row     <= n_row;
            if (n_dig_we) begin
                r_digits[r_cursor] <= key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= {1'b0, cursor_ext[2:0], row_drive, n_sec, led, port};
        end
    end

    assign o_out_data = r_out_data;

endmodule

`default_nettype wire

/* design/sskp_ctrl.sv */
// ----------------------------------------------------------------------------
// sskp_ctrl
// Sequencer for item intake, remainder run, state commit and result valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "seven_segment_scan_with_keypad_edit_assert.svh"

module sskp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire sskp_pkg::t_sts i_sts,
    output sskp_pkg::t_cmd      o_cmd
);
    import sskp_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.in_tick ? ST_REM : ST_APPLY;
                end
            end
            ST_REM: begin
                if (i_sts.rem_idle) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == ST_IDLE);
        o_cmd.load      = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.rem_start = (r_state == ST_IDLE) && i_in_valid && i_sts.in_tick;
        o_cmd.commit    = (r_state == ST_APPLY) && out_free;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `SSKP_ASSERT_NEXT(a_tick_runs_rem, i_clk, i_rst_n, o_cmd.rem_start, r_state == ST_REM && !i_sts.rem_idle)
    `SSKP_ASSERT_SAME(a_idle_rem_free, i_clk, i_rst_n, r_state == ST_IDLE, i_sts.rem_idle)
    `SSKP_ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n, o_cmd.commit, r_out_valid && r_state == ST_IDLE)

endmodule

`default_nettype wire

/* design/seven_segment_scan_with_keypad_edit.sv */
// ----------------------------------------------------------------------------
// seven_segment_scan_with_keypad_edit
// Scanned seven-segment digit drive, PWM LED and keypad digit editing.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one word per item: tuser is the op (tick, keypad
//   scan, button), tdata carries the keypad sense and button code.
//   Master stream returns exactly one result word per item.
//   Config channel writes tick_period (index 0) or blink_ticks (index 1);
//   it is always ready; the user must see that it is written only while no
//   item is in flight, since the block itself does not enforce this.
//   A tick runs the 16-step bit-serial remainder of the tick count by the
//   PWM divisor before its result is committed; other items go straight
//   to the commit. A new item is taken only once the last one has been
//   committed.
//   A finished result sits in the output register while the next item is
//   accepted and worked; the commit of that item waits until the receiver
//   takes the held word.
//   Reset (synchronous, active low) restores the default registers, digit
//   buffer 8..1, scroll 4, cursor 7, divisor 4, row 0x08, and empties the
//   output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_scan_with_keypad_edit #(
    parameter int NUM_DIGITS  = 8,
    parameter int SCAN_DIGITS = 4
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [6:0] sense, [8:7] button_code, [15:9] zero
    input  wire logic [sskp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] op
    input  wire logic [sskp_pkg::OP_W-1:0]          s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [7:0] digit_port, [8] led_on, [12:9] seconds_nibble,
    // [19:13] row_drive, [22:20] cursor, [23] zero
    output logic [sskp_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [sskp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sskp_pkg::TICK_W-1:0]        i_cfg_data
);
    import sskp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    sskp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sskp_dpath #(
        .NUM_DIGITS  (NUM_DIGITS),
        .SCAN_DIGITS (SCAN_DIGITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_op        (s_axis_tuser),
        .i_sense     (s_axis_tdata[SENSE_W-1:0]),
        .i_code      (s_axis_tdata[SENSE_W+BTN_W-1:SENSE_W]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

/* tb/tb_seven_segment_scan_with_keypad_edit.sv */
// ----------------------------------------------------------------------------
// tb_seven_segment_scan_with_keypad_edit
// Streams ticks, keypad scans and button events into the display block and
// checks every result word against a cycle-free model of the scan, blink,
// PWM, keypad edit and button logic, or the typed word of a directed row. A
// directed table comes first, then randomized phases under several settings
// of tick_period / blink_ticks with random input gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_seven_segment_scan_with_keypad_edit;

    import sskp_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int NUM_PHASES = 5;

    typedef struct packed {
        logic [7:0]         digit_port;
        logic               led_on;
        logic [SEC_W-1:0]   seconds;
        logic [DRIVE_W-1:0] row_drive;
        logic [2:0]         cursor;
    } t_disp_word;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [SENSE_W-1:0] sense;
        logic [BTN_W-1:0]   code;
        logic               typed;
        t_disp_word         want;
    } t_stim_row;

    typedef enum int { MIX_NORMAL, MIX_DIV_UP, MIX_DIV_DOWN } t_mix;

    localparam t_disp_word NO_WORD = '0;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = OP_TICK;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_TICK_PERIOD;
    logic [TICK_W-1:0]     i_cfg_data = '0;

    seven_segment_scan_with_keypad_edit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // display model state
    logic [TICK_W-1:0] period_reg;
    logic [TICK_W-1:0] blink_reg;
    logic [TICK_W-1:0] tick_cnt;
    logic [SEC_W-1:0]  sec_cnt;
    logic [1:0]        scan_idx;
    logic [2:0]        scroll;
    logic [2:0]        edit_pos;
    logic [3:0]        digit_buf [8];
    logic [DIV_W-1:0]  pwm_div;
    logic [ROW_W-1:0]  row_sel;

    t_disp_word pending_words [$];
    int         mismatches = 0;
    int         words_seen = 0;
    int         cycle_count = 0;
    int         stall_left = 0;
    bit         gaps_on = 1'b1;
    bit         stalls_on = 1'b1;

    t_stim_row   directed_rows [25];
    int unsigned phase_period [NUM_PHASES];
    int unsigned phase_blink [NUM_PHASES];
    int          phase_items [NUM_PHASES];
    t_mix        phase_mix [NUM_PHASES];

    function automatic t_disp_word next_display_word(input logic [OP_W-1:0] op,
                                                     input logic [SENSE_W-1:0] sense,
                                                     input logic [BTN_W-1:0] code);
        t_disp_word  w;
        int unsigned nxt;
        int          key;
        logic [2:0]  idx;
        logic        en;
        w = NO_WORD;
        case (op)
            OP_TICK: begin
                w.led_on = ((32'(tick_cnt) % 32'(pwm_div)) == 0);
                nxt = 32'(tick_cnt) + 1;
                if (nxt >= 32'(period_reg)) begin
                    nxt = 0;
                end
                tick_cnt = nxt[TICK_W-1:0];
                if (tick_cnt == TICK_W'(period_reg - 16'd1)) begin
                    sec_cnt = sec_cnt + SEC_W'(1);
                end
                scan_idx = scan_idx + 2'd1;
                idx = 3'(scan_idx) + scroll;
                en = !(idx == edit_pos && tick_cnt < blink_reg);
                w.digit_port = {en, 1'b0, scan_idx, digit_buf[idx]};
            end
            OP_SCAN: begin
                key = -1;
                for (int i = 0; i < NUM_KEYS; i++) begin
                    if (key < 0 && sense == KEY_CODES[i]) begin
                        key = i;
                    end
                end
                if (key == int'(KEY_CURSOR_DOWN)) begin
                    edit_pos = edit_pos - 3'd1;
                end else if (key == int'(KEY_CURSOR_UP)) begin
                    edit_pos = edit_pos + 3'd1;
                end else if (key >= 0) begin
                    digit_buf[edit_pos] = 4'(key);
                end
                row_sel = row_sel + ROW_W'(1);
            end
            OP_BUTTON: begin
                case (code)
                    BTN_SCROLL_UP:   scroll = scroll + 3'd1;
                    BTN_SCROLL_DOWN: scroll = scroll - 3'd1;
                    BTN_DIV_UP:      if (pwm_div < DIVISOR_MAX) pwm_div = pwm_div + DIV_W'(1);
                    default:         if (pwm_div > DIVISOR_MIN) pwm_div = pwm_div - DIV_W'(1);
                endcase
            end
            default: ;
        endcase
        w.seconds = sec_cnt;
        w.row_drive = ROW_BASE << row_sel;
        w.cursor = edit_pos;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("word %0d: %s got 0x%0h want 0x%0h", words_seen, what, got, want);
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic [SENSE_W-1:0] sense,
                             input logic [BTN_W-1:0] code, input logic typed,
                             input t_disp_word want);
        t_disp_word pred;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {7'd0, code, sense};
        do @(posedge i_clk); while (!s_axis_tready);
        pred = next_display_word(op, sense, code);
        pending_words.push_back(typed ? want : pred);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_words.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_TICK_PERIOD) begin
            period_reg = data;
        end else begin
            blink_reg = data;
        end
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("seven_segment_scan_with_keypad_edit: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_disp_word want;
        logic [OUT_DATA_W-1:0] got;
        got = m_axis_tdata;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            words_seen++;
            if (pending_words.size() == 0) begin
                report_mismatch("word with nothing expected", got, 0);
            end else begin
                want = pending_words.pop_front();
                if (got[7:0] != want.digit_port)
                    report_mismatch("digit_port", got[7:0], want.digit_port);
                if (got[8] != want.led_on)
                    report_mismatch("led_on", got[8], want.led_on);
                if (got[12:9] != want.seconds)
                    report_mismatch("seconds_nibble", got[12:9], want.seconds);
                if (got[19:13] != want.row_drive)
                    report_mismatch("row_drive", got[19:13], want.row_drive);
                if (got[22:20] != want.cursor)
                    report_mismatch("cursor", got[22:20], want.cursor);
            end
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin : stimulus
        logic [OP_W-1:0]    op;
        logic [SENSE_W-1:0] sense;
        logic [BTN_W-1:0]   code;
        int                 r;

        period_reg = TICK_PERIOD_RST;
        blink_reg = BLINK_TICKS_RST;
        tick_cnt = '0;
        sec_cnt = '0;
        scan_idx = '0;
        scroll = 3'd4;
        edit_pos = 3'd7;
        for (int i = 0; i < 8; i++) begin
            digit_buf[i] = 4'(8 - i);
        end
        pwm_div = DIVISOR_RST;
        row_sel = '0;

        directed_rows = '{
            '{OP_TICK,   7'd0,   BTN_SCROLL_UP,   1'b1, '{8'h93, 1'b1, 4'd0, 7'h08, 3'd7}},
            '{OP_UNUSED, 7'h7f,  BTN_DIV_DOWN,    1'b1, '{8'h00, 1'b0, 4'd0, 7'h08, 3'd7}},
            '{OP_SCAN,   7'd0,   BTN_SCROLL_UP,   1'b1, '{8'h00, 1'b0, 4'd0, 7'h10, 3'd7}},
            '{OP_SCAN,   7'd70,  BTN_SCROLL_UP,   1'b1, '{8'h00, 1'b0, 4'd0, 7'h20, 3'd0}},
            '{OP_SCAN,   7'd67,  BTN_SCROLL_UP,   1'b1, '{8'h00, 1'b0, 4'd0, 7'h40, 3'd7}},
            '{OP_SCAN,   7'd69,  BTN_SCROLL_UP,   1'b1, '{8'h00, 1'b0, 4'd0, 7'h08, 3'd7}},
            '{OP_BUTTON, 7'd0,   BTN_SCROLL_DOWN, 1'b1, '{8'h00, 1'b0, 4'd0, 7'h08, 3'd7}},
            '{OP_TICK,   7'd0,   BTN_SCROLL_UP,   1'b0, NO_WORD},
            '{OP_BUTTON, 7'd0,   BTN_SCROLL_DOWN, 1'b0, NO_WORD},
            '{OP_BUTTON, 7'd0,   BTN_SCROLL_DOWN, 1'b0, NO_WORD},
            '{OP_BUTTON, 7'd0,   BTN_SCROLL_DOWN, 1'b0, NO_WORD},
            '{OP_BUTTON, 7'd0,   BTN_SCROLL_DOWN, 1'b0, NO_WORD},
            '{OP_BUTTON, 7'd0,   BTN_SCROLL_UP,   1'b0, NO_WORD},
            '{OP_BUTTON, 7'd0,   BTN_DIV_DOWN,    1'b0, NO_WORD},
            '{OP_BUTTON, 7'd0,   BTN_DIV_DOWN,    1'b0, NO_WORD},
            '{OP_BUTTON, 7'd0,   BTN_DIV_DOWN,    1'b0, NO_WORD},
            '{OP_BUTTON, 7'd0,   BTN_DIV_DOWN,    1'b0, NO_WORD},
            '{OP_TICK,   7'd0,   BTN_SCROLL_UP,   1'b0, NO_WORD},
            '{OP_TICK,   7'h7f,  BTN_DIV_DOWN,    1'b0, NO_WORD},
            '{OP_SCAN,   7'd14,  BTN_SCROLL_UP,   1'b0, NO_WORD},
            '{OP_SCAN,   7'd35,  BTN_SCROLL_UP,   1'b0, NO_WORD},
            '{OP_SCAN,   7'h7f,  BTN_DIV_DOWN,    1'b0, NO_WORD},
            '{OP_BUTTON, 7'd0,   BTN_DIV_UP,      1'b0, NO_WORD},
            '{OP_TICK,   7'd0,   BTN_SCROLL_UP,   1'b0, NO_WORD},
            '{OP_TICK,   7'd0,   BTN_SCROLL_UP,   1'b0, NO_WORD}
        };

        phase_period = '{65535, 2, 0, 1, 7};
        phase_blink  = '{65535, 0, 1, 32768, 3};
        phase_items  = '{300, 400, 300, 250, 250};
        phase_mix    = '{MIX_NORMAL, MIX_DIV_UP, MIX_DIV_DOWN, MIX_NORMAL, MIX_NORMAL};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].op, directed_rows[i].sense, directed_rows[i].code,
                      directed_rows[i].typed, directed_rows[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            write_reg(CFG_TICK_PERIOD, TICK_W'(phase_period[p]));
            write_reg(CFG_BLINK_TICKS, TICK_W'(phase_blink[p]));
            if (p == NUM_PHASES - 1) begin
                gaps_on = 1'b0;
                stalls_on = 1'b0;
            end
            for (int n = 0; n < phase_items[p]; n++) begin
                r = $urandom_range(0, 99);
                sense = SENSE_W'($urandom_range(0, 127));
                code = BTN_W'($urandom_range(0, 3));
                case (phase_mix[p])
                    MIX_DIV_UP: op = (r < 85) ? OP_BUTTON : OP_TICK;
                    MIX_DIV_DOWN: op = (r < 30) ? OP_TICK : (r < 45) ? OP_SCAN :
                                       (r < 95) ? OP_BUTTON : OP_UNUSED;
                    default: op = (r < 40) ? OP_TICK : (r < 70) ? OP_SCAN :
                                  (r < 95) ? OP_BUTTON : OP_UNUSED;
                endcase
                if (op == OP_SCAN && $urandom_range(0, 3) != 0) begin
                    sense = KEY_CODES[$urandom_range(0, NUM_KEYS - 1)];
                end
                if (op == OP_BUTTON) begin
                    if (phase_mix[p] == MIX_DIV_UP && $urandom_range(0, 9) != 0) begin
                        code = BTN_DIV_UP;
                    end else if (phase_mix[p] == MIX_DIV_DOWN && $urandom_range(0, 9) < 7) begin
                        code = BTN_DIV_DOWN;
                    end
                end
                send_item(op, sense, code, 1'b0, NO_WORD);
                if (p < NUM_PHASES - 1 && $urandom_range(0, 199) == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("seven_segment_scan_with_keypad_edit: match");
        end else begin
            $display("seven_segment_scan_with_keypad_edit: mismatch");
        end
        $finish;
    end

endmodule
